// File: design/cot_pkg.sv
// ----------------------------------------------------------------------------
// cot_pkg
// Shared types and constants of the centroid object tracker.
// ----------------------------------------------------------------------------
package cot_pkg;

    localparam int MAX_OBJECTS_DEF = 32;
    localparam logic [9:0] MAX_AGE_RST = 10'd10;

    localparam logic signed [17:0] POS_MIN = -18'sd16384;
    localparam logic signed [17:0] POS_MAX = 18'sd16383;

    localparam logic KIND_DET = 1'b0;
    localparam logic KIND_EOF = 1'b1;

    localparam logic RK_DET    = 1'b0;
    localparam logic RK_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_NEW   = 2'd0,
        ST_MATCH = 2'd1,
        ST_DROP  = 2'd2
    } status_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [11:0] width;
        logic [11:0] height;
        logic [31:0] last_seen;
        logic [17:0] motion_x;
        logic [17:0] motion_y;
        logic [31:0] ident;
    } entry_t;

    // candidate entry going into the distance pipeline
    typedef struct packed {
        logic        vld;
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [11:0] width;
        logic [11:0] height;
        logic [31:0] ident;
        logic [31:0] age;
    } dist_in_t;

    // candidate leaving the distance pipeline
    typedef struct packed {
        logic        vld;
        logic [17:0] ddx;
        logic [17:0] ddy;
        logic [31:0] ident;
        logic [31:0] age;
        logic [32:0] dsq;
        logic [23:0] thr;
    } dist_out_t;

endpackage

// File: design/cot_dist.sv
// ----------------------------------------------------------------------------
// cot_dist
// Two-stage centre distance pipeline: differences, then squares.
// ----------------------------------------------------------------------------
module cot_dist
    import cot_pkg::*;
#(
    parameter int IW = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  dist_in_t        ent,
    input  logic [IW-1:0]   ent_idx,
    input  logic [11:0]     det_x,
    input  logic [11:0]     det_y,
    input  logic [11:0]     det_width,
    input  logic [11:0]     det_height,
    output dist_out_t       res,
    output logic [IW-1:0]   res_idx
);

    logic [17:0] cdx, cdy, cex, cey, ddx, ddy;
    logic [13:0] size_sum;

    logic              a_vld_reg;
    logic [17:0]       a_ddx_reg, a_ddy_reg;
    logic [10:0]       a_t_reg;
    logic [31:0]       a_ident_reg, a_age_reg;
    logic [IW-1:0]     a_idx_reg;

    logic signed [35:0] sqx, sqy;
    logic [21:0]        tt;

    logic              b_vld_reg;
    logic [17:0]       b_ddx_reg, b_ddy_reg;
    logic [31:0]       b_ident_reg, b_age_reg;
    logic [32:0]       b_dist_reg;
    logic [23:0]       b_thr_reg;
    logic [IW-1:0]     b_idx_reg;

    // centres in half-pixel units
    always_comb
    begin
        cdx = {5'b0, det_x, 1'b0} + {6'b0, det_width};
        cdy = {5'b0, det_y, 1'b0} + {6'b0, det_height};
        cex = {{2{ent.pos_x[14]}}, ent.pos_x, 1'b0} + {6'b0, ent.width};
        cey = {{2{ent.pos_y[14]}}, ent.pos_y, 1'b0} + {6'b0, ent.height};
        ddx = cdx - cex;
        ddy = cdy - cey;
        size_sum = {2'b0, det_width} + {2'b0, det_height}
                 + {2'b0, ent.width} + {2'b0, ent.height};
    end

    always_comb
    begin
        sqx = $signed(a_ddx_reg) * $signed(a_ddx_reg);
        sqy = $signed(a_ddy_reg) * $signed(a_ddy_reg);
        tt  = a_t_reg * a_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= ent.vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ddx_reg   <= ddx;
        a_ddy_reg   <= ddy;
        a_t_reg     <= size_sum[13:3];
        a_ident_reg <= ent.ident;
        a_age_reg   <= ent.age;
        a_idx_reg   <= ent_idx;
        b_ddx_reg   <= a_ddx_reg;
        b_ddy_reg   <= a_ddy_reg;
        b_ident_reg <= a_ident_reg;
        b_age_reg   <= a_age_reg;
        b_idx_reg   <= a_idx_reg;
        b_dist_reg  <= {1'b0, sqx[31:0]} + {1'b0, sqy[31:0]};
        b_thr_reg   <= {tt, 2'b00};
    end

    always_comb
    begin
        res.vld   = b_vld_reg;
        res.ddx   = b_ddx_reg;
        res.ddy   = b_ddy_reg;
        res.ident = b_ident_reg;
        res.age   = b_age_reg;
        res.dsq   = b_dist_reg;
        res.thr   = b_thr_reg;
        res_idx   = b_idx_reg;
    end

endmodule

// File: design/centroid_object_tracker.sv
// ----------------------------------------------------------------------------
// centroid_object_tracker
// Table of tracked boxes matched against detections by centre distance.
// ----------------------------------------------------------------------------
// Requests are taken with start while busy is low. kind selects a detection
// box (det_* fields) or an end of frame. max_age is written through cfg_write
// and cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. A detection scans the entry memory one
// slot a cycle through a read stage and a two-stage distance pipeline, then
// writes back the chosen entry; busy drops as its single result shows.
// An end of frame reads, predicts and writes back one slot a cycle and
// reports each survivor in slot order, zero to MAX_OBJECTS results, the
// final one flagged by last; busy drops with it. Busy stays high while the
// entry memory is scanned.
// Each result is shown for one cycle with result_valid high; the receiver
// cannot stall, so nothing is held back.
// Reset clears all valid bits, the frame and id counters, and sets max_age
// to 10. No clearing pass is needed: entry data is read only when valid.
// ----------------------------------------------------------------------------
module centroid_object_tracker
    import cot_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [11:0]        det_x,
    input  logic [11:0]        det_y,
    input  logic [11:0]        det_width,
    input  logic [11:0]        det_height,
    input  logic               cfg_write,
    input  logic [9:0]         cfg_data,
    output logic               result_valid,
    output logic               result_kind,
    output logic [1:0]         status,
    output logic [31:0]        object_id,
    output logic signed [14:0] pos_x,
    output logic signed [14:0] pos_y,
    output logic [11:0]        box_width,
    output logic [11:0]        box_height,
    output logic signed [17:0] motion_x,
    output logic signed [17:0] motion_y,
    output logic               last
);

    localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam logic [CW-1:0] IDX_END = CW'(MAX_OBJECTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FRAME
    } state_t;

    state_t state_reg;

    entry_t mem [MAX_OBJECTS];
    entry_t rd_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    entry_t            mem_wdata;

    logic [CW-1:0]     idx_reg;
    logic [MAX_OBJECTS-1:0] valid_reg;
    logic [31:0]       fc_reg, idc_reg;
    logic [9:0]        max_age_reg;
    logic [11:0]       dx_reg, dy_reg, dw_reg, dh_reg;

    logic              s1_tok_reg, s1_vld_reg;
    logic [IW-1:0]     s1_idx_reg;
    logic              t2_reg, t3_reg;

    logic              best_found_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [31:0]       best_age_reg, best_id_reg;
    logic [17:0]       best_mx_reg, best_my_reg;

    logic              pend_valid_reg;
    entry_t            pend_reg;

    logic              rv_reg, rk_reg, last_reg;
    logic [1:0]        st_reg;
    logic [31:0]       id_out_reg;
    logic [14:0]       px_reg, py_reg;
    logic [11:0]       bw_reg, bh_reg;
    logic [17:0]       mx_reg, my_reg;

    logic              issue;
    logic [31:0]       rd_age;
    dist_in_t          d_in;
    dist_out_t         d_out;
    logic [IW-1:0]     d_idx;
    logic              better;
    logic              free_found;
    logic [IW-1:0]     free_idx;
    logic [31:0]       id_new;
    logic              keep, seen;
    entry_t            upd;

    // pos = (2*pos + motion) / 2 toward zero, saturated
    function automatic logic [14:0] predict(input logic [14:0] p,
                                            input logic [17:0] m);
        logic [18:0] v;
        logic [18:0] vr;
        logic signed [17:0] q;
        v  = {{3{p[14]}}, p, 1'b0} + {m[17], m};
        vr = v + {18'b0, v[18]};
        q  = $signed(vr[18:1]);
        if (q < POS_MIN)
            return POS_MIN[14:0];
        else if (q > POS_MAX)
            return POS_MAX[14:0];
        else
            return q[14:0];
    endfunction

    assign busy  = (state_reg != S_IDLE);
    assign issue = ((state_reg == S_SCAN) || (state_reg == S_FRAME))
                   && (idx_reg < IDX_END);
    assign rd_age = fc_reg - rd_reg.last_seen;

    always_comb
    begin
        d_in.vld    = s1_tok_reg && s1_vld_reg && (state_reg == S_SCAN);
        d_in.pos_x  = rd_reg.pos_x;
        d_in.pos_y  = rd_reg.pos_y;
        d_in.width  = rd_reg.width;
        d_in.height = rd_reg.height;
        d_in.ident  = rd_reg.ident;
        d_in.age    = rd_age;
    end

    cot_dist #(.IW(IW)) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ent        (d_in),
        .ent_idx    (s1_idx_reg),
        .det_x      (dx_reg),
        .det_y      (dy_reg),
        .det_width  (dw_reg),
        .det_height (dh_reg),
        .res        (d_out),
        .res_idx    (d_idx)
    );

    // a zero threshold makes the compare fail on its own
    always_comb
    begin
        better = d_out.vld && (d_out.dsq < {9'b0, d_out.thr})
                 && (!best_found_reg || (d_out.age < best_age_reg)
                     || ((d_out.age == best_age_reg) && (d_out.ident < best_id_reg)));
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_OBJECTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign id_new = idc_reg + 32'd1;
    assign seen   = (rd_reg.last_seen == fc_reg);
    assign keep   = (rd_age <= {22'b0, max_age_reg});

    always_comb
    begin
        upd = rd_reg;
        if (!seen)
        begin
            upd.pos_x = predict(rd_reg.pos_x, rd_reg.motion_x);
            upd.pos_y = predict(rd_reg.pos_y, rd_reg.motion_y);
        end
    end

    // memory write port: detection write-back or frame-end update
    always_comb
    begin
        mem_we              = 1'b0;
        mem_waddr           = s1_idx_reg;
        mem_wdata           = upd;
        if (state_reg == S_FRAME)
        begin
            mem_we = s1_tok_reg && s1_vld_reg;
        end
        else if (state_reg == S_DECIDE)
        begin
            mem_we              = best_found_reg || free_found;
            mem_waddr           = best_found_reg ? best_idx_reg : free_idx;
            mem_wdata.pos_x     = {3'b0, dx_reg};
            mem_wdata.pos_y     = {3'b0, dy_reg};
            mem_wdata.width     = dw_reg;
            mem_wdata.height    = dh_reg;
            mem_wdata.last_seen = fc_reg;
            mem_wdata.motion_x  = best_found_reg ? best_mx_reg : 18'd0;
            mem_wdata.motion_y  = best_found_reg ? best_my_reg : 18'd0;
            mem_wdata.ident     = best_found_reg ? best_id_reg : id_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            fc_reg         <= '0;
            idc_reg        <= '0;
            max_age_reg    <= MAX_AGE_RST;
            s1_tok_reg     <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s1_idx_reg     <= '0;
            t2_reg         <= 1'b0;
            t3_reg         <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rv_reg         <= 1'b0;
            rk_reg         <= RK_DET;
            last_reg       <= 1'b0;
            st_reg         <= ST_NEW;
            best_idx_reg   <= '0;
            best_age_reg   <= '0;
            best_id_reg    <= '0;
            best_mx_reg    <= '0;
            best_my_reg    <= '0;
            pend_reg       <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            dw_reg         <= '0;
            dh_reg         <= '0;
            id_out_reg     <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            bw_reg         <= '0;
            bh_reg         <= '0;
            mx_reg         <= '0;
            my_reg         <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (cfg_write)
                max_age_reg <= cfg_data;

            s1_tok_reg <= issue;
            s1_vld_reg <= valid_reg[idx_reg[IW-1:0]];
            s1_idx_reg <= idx_reg[IW-1:0];
            t2_reg     <= s1_tok_reg && (state_reg == S_SCAN);
            t3_reg     <= t2_reg;
            if (issue)
                idx_reg <= idx_reg + CW'(1);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        dx_reg         <= det_x;
                        dy_reg         <= det_y;
                        dw_reg         <= det_width;
                        dh_reg         <= det_height;
                        idx_reg        <= '0;
                        best_found_reg <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= (kind == KIND_EOF) ? S_FRAME : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (t3_reg && better)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= d_idx;
                        best_age_reg   <= d_out.age;
                        best_id_reg    <= d_out.ident;
                        best_mx_reg    <= d_out.ddx;
                        best_my_reg    <= d_out.ddy;
                    end
                    if ((idx_reg == IDX_END) && !s1_tok_reg && !t2_reg && !t3_reg)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    rv_reg   <= 1'b1;
                    rk_reg   <= RK_DET;
                    last_reg <= 1'b1;
                    px_reg   <= {3'b0, dx_reg};
                    py_reg   <= {3'b0, dy_reg};
                    bw_reg   <= dw_reg;
                    bh_reg   <= dh_reg;
                    if (best_found_reg)
                    begin
                        st_reg     <= ST_MATCH;
                        id_out_reg <= best_id_reg;
                        mx_reg     <= best_mx_reg;
                        my_reg     <= best_my_reg;
                    end
                    else if (free_found)
                    begin
                        st_reg              <= ST_NEW;
                        id_out_reg          <= id_new;
                        mx_reg              <= '0;
                        my_reg              <= '0;
                        idc_reg             <= id_new;
                        valid_reg[free_idx] <= 1'b1;
                    end
                    else
                    begin
                        st_reg     <= ST_DROP;
                        id_out_reg <= '0;
                        mx_reg     <= '0;
                        my_reg     <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                S_FRAME:
                begin
                    if (s1_tok_reg && s1_vld_reg)
                    begin
                        if (!keep)
                            valid_reg[s1_idx_reg] <= 1'b0;
                        else
                        begin
                            // one-deep hold so the final survivor gets last
                            pend_valid_reg <= 1'b1;
                            pend_reg       <= upd;
                        end
                    end
                    if (s1_tok_reg && s1_vld_reg && keep && pend_valid_reg)
                    begin
                        rv_reg   <= 1'b1;
                        last_reg <= 1'b0;
                    end
                    else if ((idx_reg == IDX_END) && !s1_tok_reg)
                    begin
                        rv_reg         <= pend_valid_reg;
                        last_reg       <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        fc_reg         <= fc_reg + 32'd1;
                        state_reg      <= S_IDLE;
                    end
                    rk_reg     <= RK_REPORT;
                    st_reg     <= ST_NEW;
                    id_out_reg <= pend_reg.ident;
                    px_reg     <= pend_reg.pos_x;
                    py_reg     <= pend_reg.pos_y;
                    bw_reg     <= pend_reg.width;
                    bh_reg     <= pend_reg.height;
                    mx_reg     <= pend_reg.motion_x;
                    my_reg     <= pend_reg.motion_y;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign result_kind  = rk_reg;
    assign status       = st_reg;
    assign object_id    = id_out_reg;
    assign pos_x        = $signed(px_reg);
    assign pos_y        = $signed(py_reg);
    assign box_width    = bw_reg;
    assign box_height   = bh_reg;
    assign motion_x     = $signed(mx_reg);
    assign motion_y     = $signed(my_reg);
    assign last         = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !busy) |-> last)
        else $error("result after going idle is not flagged last");

    a_report_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == RK_REPORT)) |-> (status == ST_NEW))
        else $error("report carries a nonzero status");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_DROP)) |->
            ((object_id == 32'd0) && (motion_x == 18'sd0) && (motion_y == 18'sd0)))
        else $error("dropped detection has nonzero id or motion");

endmodule
